@@ design/ecpad_pkg.sv @@
// Shared types, constants and the micro-op table for the affine point add/double core.
// No dependencies; used by ecpad_ctrl, ecpad_dp and the top level.
package ecpad_pkg;

	localparam int FIELD_BITS = 32;
	localparam int BIT_IDX_W = $clog2(FIELD_BITS);
	localparam int PC_W = 5;

	localparam logic [FIELD_BITS-1:0] MODULUS_RST = 32'd4294967291;
	localparam logic [FIELD_BITS-1:0] CURVE_A_RST = '0;

	localparam logic [1:0] CFG_MODULUS = 2'd0;
	localparam logic [1:0] CFG_CURVE_A = 2'd1;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	// operand sources
	localparam logic [3:0] SRC_X1 = 4'd0;
	localparam logic [3:0] SRC_Y1 = 4'd1;
	localparam logic [3:0] SRC_X2 = 4'd2;
	localparam logic [3:0] SRC_Y2 = 4'd3;
	localparam logic [3:0] SRC_A = 4'd4;
	localparam logic [3:0] SRC_T0 = 4'd5;
	localparam logic [3:0] SRC_T1 = 4'd6;
	localparam logic [3:0] SRC_T2 = 4'd7;
	localparam logic [3:0] SRC_ONE = 4'd8;
	localparam logic [3:0] SRC_ZERO = 4'd9;

	localparam logic [2:0] R_X1 = 3'd0;
	localparam logic [2:0] R_Y1 = 3'd1;
	localparam logic [2:0] R_X2 = 3'd2;
	localparam logic [2:0] R_Y2 = 3'd3;
	localparam logic [2:0] R_A = 3'd4;
	localparam logic [2:0] R_T0 = 3'd5;
	localparam logic [2:0] R_T1 = 3'd6;
	localparam logic [2:0] R_T2 = 3'd7;

	localparam logic [1:0] CAP_RES = 2'd0;
	localparam logic [1:0] CAP_P1 = 2'd1;
	localparam logic [1:0] CAP_P2 = 2'd2;

	// program segments
	localparam logic [PC_W-1:0] PC_RED = 5'd0;
	localparam logic [PC_W-1:0] PC_RED_END = 5'd4;
	localparam logic [PC_W-1:0] PC_DBL = 5'd5;
	localparam logic [PC_W-1:0] PC_DBL_END = 5'd10;
	localparam logic [PC_W-1:0] PC_ADD = 5'd11;
	localparam logic [PC_W-1:0] PC_ADD_END = 5'd12;
	localparam logic [PC_W-1:0] PC_INI = 5'd13;
	localparam logic [PC_W-1:0] PC_SQ = 5'd14;
	localparam logic [PC_W-1:0] PC_ML = 5'd15;
	localparam logic [PC_W-1:0] PC_TAIL = 5'd16;
	localparam logic [PC_W-1:0] PC_TAIL_END = 5'd22;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] sa;
		logic [3:0] sb;
		logic [2:0] dst;
	} uop_t;

	typedef struct packed {
		logic load;
		logic start;
		uop_t uop;
		logic [BIT_IDX_W-1:0] bit_idx;
		logic cap;
		logic cap_inf;
		logic [1:0] cap_sel;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic x_eq;
		logic y_eq;
		logic y1_zero;
		logic p_small;
		logic e_bit;
	} sts_t;

	function automatic uop_t mk(input logic [1:0] op, input logic [3:0] sa,
		input logic [3:0] sb, input logic [2:0] dst);
		uop_t u;
		u.op = op;
		u.sa = sa;
		u.sb = sb;
		u.dst = dst;
		return u;
	endfunction

	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// reduce operands: 1 * v mod p
			5'd0: u = mk(OP_MUL, SRC_ONE, SRC_X1, R_X1);
			5'd1: u = mk(OP_MUL, SRC_ONE, SRC_Y1, R_Y1);
			5'd2: u = mk(OP_MUL, SRC_ONE, SRC_X2, R_X2);
			5'd3: u = mk(OP_MUL, SRC_ONE, SRC_Y2, R_Y2);
			5'd4: u = mk(OP_MUL, SRC_ONE, SRC_A, R_A);
			// doubling slope: num = 3x^2 + a, den = 2y
			5'd5: u = mk(OP_MUL, SRC_X1, SRC_X1, R_T0);
			5'd6: u = mk(OP_ADD, SRC_T0, SRC_T0, R_T1);
			5'd7: u = mk(OP_ADD, SRC_T1, SRC_T0, R_T0);
			5'd8: u = mk(OP_ADD, SRC_T0, SRC_A, R_T0);
			5'd9: u = mk(OP_ADD, SRC_Y1, SRC_Y1, R_T1);
			5'd10: u = mk(OP_ADD, SRC_X1, SRC_ZERO, R_X2);
			// addition slope
			5'd11: u = mk(OP_SUB, SRC_Y1, SRC_Y2, R_T0);
			5'd12: u = mk(OP_SUB, SRC_X1, SRC_X2, R_T1);
			// inversion by square and multiply
			5'd13: u = mk(OP_ADD, SRC_ONE, SRC_ZERO, R_T2);
			5'd14: u = mk(OP_MUL, SRC_T2, SRC_T2, R_T2);
			5'd15: u = mk(OP_MUL, SRC_T2, SRC_T1, R_T2);
			// m in T0, x3 in T2, y3 in T1
			5'd16: u = mk(OP_MUL, SRC_T0, SRC_T2, R_T0);
			5'd17: u = mk(OP_MUL, SRC_T0, SRC_T0, R_T2);
			5'd18: u = mk(OP_SUB, SRC_T2, SRC_X1, R_T2);
			5'd19: u = mk(OP_SUB, SRC_T2, SRC_X2, R_T2);
			5'd20: u = mk(OP_SUB, SRC_X1, SRC_T2, R_T1);
			5'd21: u = mk(OP_MUL, SRC_T0, SRC_T1, R_T1);
			5'd22: u = mk(OP_SUB, SRC_T1, SRC_Y1, R_T1);
			default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, R_T2);
		endcase
		return u;
	endfunction

endpackage

@@ design/ecpad_dp.sv @@
// Datapath: operand registers, config registers, modular add/sub and a bit-serial
// modular multiplier, plus the result register. Depends on ecpad_pkg.
module ecpad_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ecpad_pkg::cmd_t                  cmd,
	output ecpad_pkg::sts_t                  sts,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [ecpad_pkg::FIELD_BITS-1:0] cfg_data,
	input  logic [ecpad_pkg::FIELD_BITS-1:0] x1,
	input  logic [ecpad_pkg::FIELD_BITS-1:0] y1,
	input  logic [ecpad_pkg::FIELD_BITS-1:0] x2,
	input  logic [ecpad_pkg::FIELD_BITS-1:0] y2,
	output logic [ecpad_pkg::FIELD_BITS-1:0] x_out,
	output logic [ecpad_pkg::FIELD_BITS-1:0] y_out,
	output logic                             out_is_identity
);
	import ecpad_pkg::*;

	localparam int W = FIELD_BITS;

	logic [W-1:0] p_q, a_cfg_q;
	logic [W-1:0] x1_q, y1_q, x2_q, y2_q, a_q, t0_q, t1_q, t2_q;
	logic [W-1:0] opa, opb, as_res, mul_next, wr_data;
	logic [W:0] sum, sum_red, dif;
	logic [W:0] dbl, dbl_red, acc, acc_red;
	logic [W-1:0] mul_a_q, mul_b_q, mul_r_q;
	logic [BIT_IDX_W-1:0] mul_cnt_q;
	logic mul_busy_q, done_q, wr_en;
	logic [2:0] mul_dst_q, wr_dst;
	logic [W-1:0] e_val;
	logic [W-1:0] xo_q, yo_q;
	logic inf_q;

	function automatic logic [W-1:0] rd(input logic [3:0] s, input logic [W-1:0] rx1,
		input logic [W-1:0] ry1, input logic [W-1:0] rx2, input logic [W-1:0] ry2,
		input logic [W-1:0] ra, input logic [W-1:0] rt0, input logic [W-1:0] rt1,
		input logic [W-1:0] rt2);
		logic [W-1:0] v;
		case (s)
			SRC_X1: v = rx1;
			SRC_Y1: v = ry1;
			SRC_X2: v = rx2;
			SRC_Y2: v = ry2;
			SRC_A: v = ra;
			SRC_T0: v = rt0;
			SRC_T1: v = rt1;
			SRC_T2: v = rt2;
			SRC_ONE: v = W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opa = rd(cmd.uop.sa, x1_q, y1_q, x2_q, y2_q, a_q, t0_q, t1_q, t2_q);
	assign opb = rd(cmd.uop.sb, x1_q, y1_q, x2_q, y2_q, a_q, t0_q, t1_q, t2_q);

	// combinational modular add and subtract
	always_comb begin
		sum = {1'b0, opa} + {1'b0, opb};
		sum_red = (sum >= {1'b0, p_q}) ? sum - {1'b0, p_q} : sum;
		dif = {1'b0, opa} - {1'b0, opb};
		if (opa < opb)
			dif = dif + {1'b0, p_q};
		as_res = (cmd.uop.op == OP_SUB) ? dif[W-1:0] : sum_red[W-1:0];
	end

	// one multiplier bit per cycle, msb first: r = 2r (+a) mod p
	always_comb begin
		dbl = {mul_r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, p_q}) ? dbl - {1'b0, p_q} : dbl;
		acc = dbl_red + {1'b0, mul_a_q};
		acc_red = (acc >= {1'b0, p_q}) ? acc - {1'b0, p_q} : acc;
		mul_next = mul_b_q[mul_cnt_q] ? acc_red[W-1:0] : dbl_red[W-1:0];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_dst = cmd.uop.dst;
		wr_data = as_res;
		if (mul_busy_q && mul_cnt_q == '0) begin
			wr_en = 1'b1;
			wr_dst = mul_dst_q;
			wr_data = mul_next;
		end else if (cmd.start && cmd.uop.op != OP_MUL) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= MODULUS_RST;
			a_cfg_q <= CURVE_A_RST;
			mul_busy_q <= 1'b0;
			done_q <= 1'b0;
			mul_cnt_q <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_MODULUS)
				p_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_CURVE_A)
				a_cfg_q <= cfg_data;
			done_q <= (mul_busy_q && mul_cnt_q == '0) ||
				(cmd.start && cmd.uop.op != OP_MUL);
			if (cmd.start && cmd.uop.op == OP_MUL) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q <= BIT_IDX_W'(W - 1);
			end else if (mul_busy_q) begin
				mul_cnt_q <= mul_cnt_q - 1'b1;
				if (mul_cnt_q == '0)
					mul_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && cmd.uop.op == OP_MUL) begin
			mul_a_q <= opa;
			mul_b_q <= opb;
			mul_r_q <= '0;
			mul_dst_q <= cmd.uop.dst;
		end else if (mul_busy_q) begin
			mul_r_q <= mul_next;
		end
		if (cmd.load) begin
			x1_q <= x1;
			y1_q <= y1;
			x2_q <= x2;
			y2_q <= y2;
			a_q <= a_cfg_q;
		end else if (wr_en) begin
			case (wr_dst)
				R_X1: x1_q <= wr_data;
				R_Y1: y1_q <= wr_data;
				R_X2: x2_q <= wr_data;
				R_Y2: y2_q <= wr_data;
				R_A: a_q <= wr_data;
				R_T0: t0_q <= wr_data;
				R_T1: t1_q <= wr_data;
				R_T2: t2_q <= wr_data;
				default: t2_q <= wr_data;
			endcase
		end
		if (cmd.cap) begin
			inf_q <= cmd.cap_inf;
			if (cmd.cap_inf) begin
				xo_q <= '0;
				yo_q <= '0;
			end else begin
				case (cmd.cap_sel)
					CAP_P1: begin
						xo_q <= x1_q;
						yo_q <= y1_q;
					end
					CAP_P2: begin
						xo_q <= x2_q;
						yo_q <= y2_q;
					end
					default: begin
						xo_q <= t2_q;
						yo_q <= t1_q;
					end
				endcase
			end
		end
	end

	assign e_val = p_q - W'(2);

	always_comb begin
		sts.done = done_q;
		sts.x_eq = (x1_q == x2_q);
		sts.y_eq = (y1_q == y2_q);
		sts.y1_zero = (y1_q == '0);
		sts.p_small = (p_q < W'(3));
		sts.e_bit = e_val[cmd.bit_idx];
	end

	assign x_out = xo_q;
	assign y_out = yo_q;
	assign out_is_identity = inf_q;

endmodule

@@ design/ecpad_ctrl.sv @@
// Controller: sequences the micro-ops of reduction, slope, inversion and result,
// and handles the special cases. Depends on ecpad_pkg.
module ecpad_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            command,
	input  logic            first_is_identity,
	input  logic            second_is_identity,
	output logic            out_valid,
	input  logic            out_ready,
	output ecpad_pkg::cmd_t cmd,
	input  ecpad_pkg::sts_t sts
);
	import ecpad_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_DBL = 4'd3;
	localparam logic [3:0] S_ADD = 4'd4;
	localparam logic [3:0] S_INI = 4'd5;
	localparam logic [3:0] S_SQ = 4'd6;
	localparam logic [3:0] S_ML = 4'd7;
	localparam logic [3:0] S_TAIL = 4'd8;
	localparam logic [3:0] S_FIN = 4'd9;

	logic [3:0] state_q;
	logic [PC_W-1:0] pc_q;
	logic issued_q, dbl_q, inf1_q, inf2_q;
	logic fin_inf_q;
	logic [1:0] fin_sel_q;
	logic [BIT_IDX_W-1:0] bit_q;
	logic out_valid_q;
	logic in_acc, run, step_done, cap;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign run = (state_q != S_IDLE) && (state_q != S_DEC) && (state_q != S_FIN);
	assign step_done = run && issued_q && sts.done;
	assign cap = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_acc;
		cmd.start = run && !issued_q;
		cmd.uop = uop_rom(pc_q);
		cmd.bit_idx = bit_q;
		cmd.cap = cap;
		cmd.cap_inf = fin_inf_q;
		cmd.cap_sel = fin_sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= PC_RED;
			issued_q <= 1'b0;
			dbl_q <= 1'b0;
			inf1_q <= 1'b0;
			inf2_q <= 1'b0;
			fin_inf_q <= 1'b0;
			fin_sel_q <= CAP_RES;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new capture replaces a result taken in the same cycle
			if (cap)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.start)
				issued_q <= 1'b1;
			else if (step_done)
				issued_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						dbl_q <= command;
						inf1_q <= first_is_identity;
						inf2_q <= second_is_identity;
						pc_q <= PC_RED;
						if (sts.p_small) begin
							fin_inf_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (step_done) begin
						if (pc_q == PC_RED_END)
							state_q <= S_DEC;
						else
							pc_q <= pc_q + 1'b1;
					end
				end
				S_DEC: begin
					if (inf1_q) begin
						fin_inf_q <= dbl_q || inf2_q;
						fin_sel_q <= CAP_P2;
						state_q <= S_FIN;
					end else if (!dbl_q && inf2_q) begin
						fin_inf_q <= 1'b0;
						fin_sel_q <= CAP_P1;
						state_q <= S_FIN;
					end else if (!dbl_q && sts.x_eq && !sts.y_eq) begin
						fin_inf_q <= 1'b1;
						state_q <= S_FIN;
					end else if ((dbl_q || sts.x_eq) && sts.y1_zero) begin
						fin_inf_q <= 1'b1;
						state_q <= S_FIN;
					end else if (dbl_q || sts.x_eq) begin
						pc_q <= PC_DBL;
						state_q <= S_DBL;
					end else begin
						pc_q <= PC_ADD;
						state_q <= S_ADD;
					end
				end
				S_DBL: begin
					if (step_done) begin
						if (pc_q == PC_DBL_END) begin
							pc_q <= PC_INI;
							state_q <= S_INI;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				S_ADD: begin
					if (step_done) begin
						if (pc_q == PC_ADD_END) begin
							pc_q <= PC_INI;
							state_q <= S_INI;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				S_INI: begin
					if (step_done) begin
						bit_q <= BIT_IDX_W'(FIELD_BITS - 1);
						pc_q <= PC_SQ;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (step_done) begin
						if (sts.e_bit) begin
							pc_q <= PC_ML;
							state_q <= S_ML;
						end else if (bit_q == '0) begin
							pc_q <= PC_TAIL;
							state_q <= S_TAIL;
						end else begin
							bit_q <= bit_q - 1'b1;
						end
					end
				end
				S_ML: begin
					if (step_done) begin
						if (bit_q == '0) begin
							pc_q <= PC_TAIL;
							state_q <= S_TAIL;
						end else begin
							bit_q <= bit_q - 1'b1;
							pc_q <= PC_SQ;
							state_q <= S_SQ;
						end
					end
				end
				S_TAIL: begin
					if (step_done) begin
						if (pc_q == PC_TAIL_END) begin
							fin_inf_q <= 1'b0;
							fin_sel_q <= CAP_RES;
							state_q <= S_FIN;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					if (cap)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ design/ec_affine_point_add_double_core.sv @@
// Top level of the affine point add/double core over GF(p), inversion included.
// Instantiates ecpad_ctrl and ecpad_dp; depends on ecpad_pkg.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    command, x1, y1, first_is_identity, x2, y2,
//                                    second_is_identity
//   out       out_valid / out_ready  x_out, y_out, out_is_identity
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (0 modulus, 1 curve_a)
//
// One request at a time. A modular multiply step is issued, runs through 32 multiplier
// bits and completes; an add or subtract is issued and completes. A full add costs
// (5 + 32 + popcount(p-2) + 3) multiplies, a double one more; special cases finish
// right after the five reductions, or without them when the modulus is below 3.
// Reset is asynchronous, active low; it sets modulus to 2^32-5 and curve_a to 0.
// A result waits in the output register while in_ready is high again; a stalled
// result blocks only the final capture of the next one.
module ec_affine_point_add_double_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [31:0] x1,
	input  logic [31:0] y1,
	input  logic        first_is_identity,
	input  logic [31:0] x2,
	input  logic [31:0] y2,
	input  logic        second_is_identity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] x_out,
	output logic [31:0] y_out,
	output logic        out_is_identity,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ecpad_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ecpad_ctrl u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.first_is_identity  (first_is_identity),
		.second_is_identity (second_is_identity),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.cmd                (cmd),
		.sts                (sts)
	);

	ecpad_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.x1              (x1),
		.y1              (y1),
		.x2              (x2),
		.y2              (y2),
		.x_out           (x_out),
		.y_out           (y_out),
		.out_is_identity (out_is_identity)
	);

endmodule

@@ design/ecpad_chk.sv @@
// Port-level checker for the affine point add/double core, bound to the top level.
// No package dependency.
module ecpad_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] x_out,
	input logic [31:0] y_out,
	input logic        out_is_identity
);

	// identity results carry zero coordinates
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_identity |-> x_out == 32'd0 && y_out == 32'd0)
		else $error("identity result with nonzero coordinates");

	// an accepted request keeps the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one still in flight");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out)
			&& $stable(out_is_identity))
		else $error("stalled result changed");

endmodule

bind ec_affine_point_add_double_core ecpad_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.x_out           (x_out),
	.y_out           (y_out),
	.out_is_identity (out_is_identity)
);

@@ verif/ecpad_checker.sv @@
`timescale 1ns / 100ps
// Watches the request, result and register channels of the affine point add/double core,
// predicts each result in plain modular arithmetic and compares. Depends on ecpad_pkg.
module ecpad_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [31:0] x1,
	input  logic [31:0] y1,
	input  logic        first_is_identity,
	input  logic [31:0] x2,
	input  logic [31:0] y2,
	input  logic        second_is_identity,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] x_out,
	input  logic [31:0] y_out,
	input  logic        out_is_identity,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	import ecpad_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        inf;
	} point_t;

	logic [31:0] field_p;
	logic [31:0] coeff_a;
	point_t      sum_q[$];

	function automatic logic [63:0] fmulmod(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] p);
		return (a * b) % p;
	endfunction

	function automatic logic [63:0] faddmod(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] p);
		return (a + b) % p;
	endfunction

	function automatic logic [63:0] fsubmod(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] p);
		return (a >= b) ? a - b : a + p - b;
	endfunction

	// Fermat inverse; zero maps to zero, composite moduli just run the same ladder
	function automatic logic [63:0] finvmod(input logic [63:0] t, input logic [63:0] p);
		logic [63:0] e;
		logic [63:0] r;
		e = p - 2;
		r = 1 % p;
		for (int i = 63; i >= 0; i--) begin
			r = fmulmod(r, r, p);
			if (e[i])
				r = fmulmod(r, t, p);
		end
		return r;
	endfunction

	function automatic point_t point_sum(input logic dbl_in, input logic [31:0] ax,
		input logic [31:0] ay, input logic inf1, input logic [31:0] bx,
		input logic [31:0] by, input logic inf2);
		logic [63:0] p, a, px, py, qx, qy, num, den, m, rx, ry;
		logic        dbl;
		point_t      res;
		res = '{x: '0, y: '0, inf: 1'b1};
		dbl = dbl_in;
		p = {32'd0, field_p};
		if (p < 3)
			return res;
		a = coeff_a % p;
		px = ax % p;
		py = ay % p;
		qx = bx % p;
		qy = by % p;
		if (inf1) begin
			if (dbl || inf2)
				return res;
			return '{x: qx[31:0], y: qy[31:0], inf: 1'b0};
		end
		if (!dbl) begin
			if (inf2)
				return '{x: px[31:0], y: py[31:0], inf: 1'b0};
			if (px == qx) begin
				if (py != qy)
					return res;
				dbl = 1'b1;
			end
		end
		if (dbl) begin
			if (py == 0)
				return res;
			num = fmulmod(px, px, p);
			num = faddmod(faddmod(num, num, p), num, p);
			num = faddmod(num, a, p);
			den = faddmod(py, py, p);
			qx = px;
		end else begin
			num = fsubmod(py, qy, p);
			den = fsubmod(px, qx, p);
		end
		m = fmulmod(num, finvmod(den, p), p);
		rx = fsubmod(fsubmod(fmulmod(m, m, p), px, p), qx, p);
		ry = fsubmod(fmulmod(m, fsubmod(px, rx, p), p), py, p);
		return '{x: rx[31:0], y: ry[31:0], inf: 1'b0};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			field_p <= MODULUS_RST;
			coeff_a <= CURVE_A_RST;
			sum_q.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MODULUS)
					field_p <= cfg_data;
				else if (cfg_index == CFG_CURVE_A)
					coeff_a <= cfg_data;
			end
			if (in_valid && in_ready)
				sum_q.push_back(point_sum(command, x1, y1, first_is_identity, x2, y2,
					second_is_identity));
			if (out_valid && out_ready) begin
				result_count++;
				if (sum_q.size() == 0) begin
					report_mismatch("unexpected result", x_out, 32'd0);
				end else begin
					want = sum_q.pop_front();
					if (x_out !== want.x)
						report_mismatch("x_out", x_out, want.x);
					if (y_out !== want.y)
						report_mismatch("y_out", y_out, want.y);
					if (out_is_identity !== want.inf)
						report_mismatch("out_is_identity", {31'd0, out_is_identity},
							{31'd0, want.inf});
				end
			end
		end
		pending = sum_q.size();
	end

endmodule

@@ verif/tb_ec_affine_point_add_double_core.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the affine point add/double core over several field settings.
// Depends on ecpad_pkg, ec_affine_point_add_double_core and ecpad_checker.
module tb_ec_affine_point_add_double_core;
	import ecpad_pkg::*;

	localparam longint CYCLE_LIMIT = 12000000;
	localparam int     HOLD_CYCLES = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [31:0] x1 = '0;
	logic [31:0] y1 = '0;
	logic        first_is_identity = 1'b0;
	logic [31:0] x2 = '0;
	logic [31:0] y2 = '0;
	logic        second_is_identity = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] x_out;
	logic [31:0] y_out;
	logic        out_is_identity;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_MODULUS;
	logic [31:0] cfg_data = '0;

	int     fail_count;
	int     pending;
	int     result_count;
	int     idle_mode = 0;
	bit     hold_request = 1'b0;
	longint cycles = 0;
	logic [31:0] cur_p = MODULUS_RST;

	always #1 clk = ~clk;

	ec_affine_point_add_double_core dut (.*);

	ecpad_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_ec_affine_point_add_double_core failed");
			$finish;
		end
	end

	function automatic bit roll_idle(input bit sender);
		int pct;
		if (idle_mode == 2)
			return 1'b0;
		pct = ((idle_mode == 0) == sender) ? 35 : 62;
		return $urandom_range(0, 99) < pct;
	endfunction

	// result side: random back-pressure plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= arst_n && !roll_idle(1'b0);
		end
	end

	task automatic send_request(input logic cmd, input logic [31:0] ax, input logic [31:0] ay,
		input logic inf1, input logic [31:0] bx, input logic [31:0] by, input logic inf2);
		@(negedge clk);
		while (roll_idle(1'b1)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		x1 <= ax;
		y1 <= ay;
		first_is_identity <= inf1;
		x2 <= bx;
		y2 <= by;
		second_is_identity <= inf2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_MODULUS)
			cur_p = val;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0 || cur_p < 3)
			return $urandom;
		if (r == 1)
			return '0;
		if (r == 2)
			return cur_p - 1;
		return $urandom % cur_p;
	endfunction

	task automatic random_request();
		int          r;
		logic [31:0] ax, ay, bx, by;
		logic        cmd, inf1, inf2;
		r = $urandom_range(0, 99);
		ax = pick_coord();
		ay = pick_coord();
		bx = pick_coord();
		by = pick_coord();
		cmd = 1'b0;
		inf1 = (r < 6);
		inf2 = (r >= 6 && r < 12) || ($urandom_range(0, 49) == 0);
		if (r >= 12 && r < 35) begin
			cmd = 1'b1;
			if ($urandom_range(0, 7) == 0)
				ay = '0;
		end else if (r >= 35 && r < 48) begin
			bx = ax;
			by = $urandom_range(0, 1) ? ay : pick_coord();
		end
		send_request(cmd, ax, ay, inf1, bx, by, inf2);
	endtask

	typedef struct {
		logic [31:0] p;
		logic [31:0] a;
		int          n;
	} field_cfg_t;

	initial begin
		field_cfg_t phases[7];
		phases[0] = '{32'hFFFF_FFFB, 32'd0, 90};
		phases[1] = '{32'd97, 32'd2, 70};
		phases[2] = '{32'd3, 32'hFFFF_FFFF, 60};
		phases[3] = '{32'hFFFF_FFFF, 32'h1234_5678, 70};
		phases[4] = '{32'd2, 32'd5, 12};
		phases[5] = '{32'd1000, 32'd7, 60};
		phases[6] = '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 90};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		idle_mode = 2;
		// identity operands, equal x, y of zero, unreduced and extreme coordinates
		send_request(1'b0, 32'd5, 32'd7, 1'b1, 32'd11, 32'd13, 1'b0);
		send_request(1'b0, 32'd5, 32'd7, 1'b0, 32'd11, 32'd13, 1'b1);
		send_request(1'b0, 32'd5, 32'd7, 1'b1, 32'd11, 32'd13, 1'b1);
		send_request(1'b1, 32'd5, 32'd7, 1'b1, 32'd11, 32'd13, 1'b0);
		send_request(1'b0, 32'd9, 32'd4, 1'b0, 32'd9, 32'd4, 1'b0);
		send_request(1'b0, 32'd9, 32'd4, 1'b0, 32'd9, 32'd6, 1'b0);
		send_request(1'b1, 32'd9, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0);
		send_request(1'b1, 32'd9, 32'hFFFF_FFFB, 1'b0, 32'd1, 32'd1, 1'b1);
		send_request(1'b0, 32'd1, 32'd2, 1'b0, 32'd3, 32'd5, 1'b0);
		send_request(1'b1, 32'd1, 32'd2, 1'b0, 32'd3, 32'd5, 1'b0);
		send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0);
		send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0);
		send_request(1'b1, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 1'b0, 32'hFFFF_FFFF, 32'd3, 1'b1);
		send_request(1'b0, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 1'b0);
		send_request(1'b0, 32'hFFFF_FFFB, 32'd8, 1'b0, 32'd0, 32'd8, 1'b0);
		send_request(1'b1, 32'd0, 32'd1, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_request(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h5555_5555,
			32'hAAAA_AAAA, 1'b0);
		wait_drained();

		foreach (phases[i]) begin
			write_reg(CFG_MODULUS, phases[i].p);
			write_reg(CFG_CURVE_A, phases[i].a);
			idle_mode = (i * 3) / 7;
			if (i == 0)
				hold_request = 1'b1;
			repeat (phases[i].n) random_request();
			wait_drained();
		end

		$display("%0d results checked over 7 field settings, including unreduced inputs,",
			result_count);
		$display("moduli below three, even and composite moduli and a long result stall");
		if (fail_count == 0)
			$display("tb_ec_affine_point_add_double_core passed");
		else
			$display("tb_ec_affine_point_add_double_core failed");
		$finish;
	end

endmodule
